/* rtl/adcma_pkg.sv */
// ============================================================================
// adcma_pkg
// Shared types and constants of the ADC range check and moving average block.
// ============================================================================
package adcma_pkg;

    localparam int VALUE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MAX       = 2'd2;

    localparam logic [VALUE_W-1:0] CODE_MIN_RESET = 16'h0000;
    localparam logic [VALUE_W-1:0] CODE_MAX_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } adcma_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/adcma_if.sv */
// ============================================================================
// adcma_if
// Valid/ready channels for samples in and filtered results out.
// ============================================================================
interface adcma_in_if
    import adcma_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] adc_code;
    logic               hard_fault;

    modport source (output valid, output adc_code, output hard_fault, input ready);
    modport sink   (input valid, input adc_code, input hard_fault, output ready);
endinterface

interface adcma_out_if
    import adcma_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_out;
    logic               fault;

    modport source (output valid, output value_out, output fault, input ready);
    modport sink   (input valid, input value_out, input fault, output ready);
endinterface

/* rtl/adcma_div.sv */
// ============================================================================
// adcma_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module adcma_div
    import adcma_pkg::*;
#(
    parameter int DVD_W = 21,
    parameter int DVR_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_status_t      status
);

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVR_W-1:0]  rem_reg, rem_next;
    logic [DVR_W-1:0]  dvr_reg, dvr_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DVR_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        ge        = (trial >= {1'b0, dvr_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvr_next = divisor;
            cnt_next = ITER_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? DVR_W'(trial - {1'b0, dvr_reg}) : trial[DVR_W-1:0];
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ITER_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

/* rtl/adc_range_check_moving_average_unit.sv */
// ============================================================================
// adc_range_check_moving_average_unit
// Range check of ADC codes with a moving average over the current sample and up to WINDOW earlier ones.
// ============================================================================
//
//  Channel   Dir  Signals                          Request taken when
//  --------  ---  -------------------------------  ------------------------
//  sample    in   adc_code[15:0], hard_fault       sample.valid & ready
//  result    out  value_out[15:0], fault           result.valid & ready
//  cfg       in   cfg_we, cfg_index[1:0], cfg_wdata  cfg_we high
//
//  Faulted or non-averaged requests: result is loaded at the accept edge,
//  shown on the next cycle; a new request can follow right away unless the result stalls.
//  Averaged requests: the ring read and history update, then SUM_W
//  bit-serial divider steps, then the divider done flag, and last the
//  load of the output register from the quotient.
//  Reset clears the history, the state and the output valid flag; the sample ring
//  needs no clearing, since a slot's value is used only once it holds a sample.
//  A stalled result holds the output register; the block takes no new
//  request until that register is free or being drained.
//
module adc_range_check_moving_average_unit
    import adcma_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    adcma_in_if.sink              sample,
    adcma_out_if.source           result
);

    // Sum of up to WINDOW+1 codes, count up to WINDOW+1
    localparam int SUM_W  = VALUE_W + $clog2(WINDOW + 1);
    localparam int CNT_W  = $clog2(WINDOW + 2);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Configuration
    logic               avg_en_reg;
    logic [VALUE_W-1:0] code_min_reg;
    logic [VALUE_W-1:0] code_max_reg;

    // Sequencer and history
    adcma_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [VALUE_W-1:0] code_reg, code_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_fault_reg, out_fault_next;

    // Sample ring, registered read
    logic [VALUE_W-1:0] ring [WINDOW];
    logic [VALUE_W-1:0] ring_rd_reg;
    logic               ring_we;

    // Divider
    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    logic [SUM_W-1:0]   div_quotient;
    div_status_t        div_status;

    logic               accept;
    logic               in_fault;
    logic               full;

    assign sample.ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept       = sample.valid && sample.ready;
    assign in_fault     = (sample.adc_code < code_min_reg) ||
                          (sample.adc_code > code_max_reg) || sample.hard_fault;
    assign full         = (fill_reg == CNT_W'(WINDOW));

    assign div_dividend = total_reg + SUM_W'(code_reg);
    assign div_divisor  = fill_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_fault_next = out_fault_reg;
        ring_we        = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    code_next = sample.adc_code;
                    if (in_fault || !avg_en_reg)
                    begin
                        // pass-through: drop the history, answer now
                        fill_next      = '0;
                        slot_next      = '0;
                        total_next     = '0;
                        out_valid_next = 1'b1;
                        out_value_next = sample.adc_code;
                        out_fault_next = in_fault;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                // oldest sample sits at the write slot once the ring is full
                div_start  = 1'b1;
                ring_we    = 1'b1;
                total_next = div_dividend - (full ? SUM_W'(ring_rd_reg) : '0);
                if (!full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = div_quotient[VALUE_W-1:0];
                    out_fault_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        out_value_reg <= out_value_next;
        out_fault_reg <= out_fault_next;
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_en_reg   <= 1'b0;
            code_min_reg <= CODE_MIN_RESET;
            code_max_reg <= CODE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AVERAGE_ENABLE: avg_en_reg   <= cfg_wdata[0];
                CFG_CODE_MIN:       code_min_reg <= cfg_wdata[VALUE_W-1:0];
                CFG_CODE_MAX:       code_max_reg <= cfg_wdata[VALUE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Ring: read at the write slot on accept, write back in the load cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_rd_reg <= ring[slot_reg];
        end
        if (ring_we)
        begin
            ring[slot_reg] <= code_reg;
        end
    end

    adcma_div #(
        .DVD_W (SUM_W),
        .DVR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign result.valid     = out_valid_reg;
    assign result.value_out = out_value_reg;
    assign result.fault     = out_fault_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !sample.ready)
        else $error("request taken while an average is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("history holds more than WINDOW samples");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> div_status.busy)
        else $error("divider not running after load");

endmodule
